// ----- sv/vau_pkg.sv -----
// ----------------------------------------------------------------------------
// vau_pkg
// Shared constants, control struct and arctangent table for the vector angle
// unit.
// ----------------------------------------------------------------------------
package vau_pkg;

   localparam int COORD_WIDTH_DEF   = 16;
   localparam int ANGLE_BITS_DEF    = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   // Fixed-point guard bits on the CORDIC vector, and size of the atan table.
   localparam int GUARD_SHIFT  = 24;
   localparam int ATAN_ENTRIES = 24;
   // Angle accumulator: 2^TURN_WIDTH units per full turn.
   localparam int TURN_WIDTH   = 32;

   localparam logic [1:0] FUNC_ANGLE  = 2'd0;
   localparam logic [1:0] FUNC_CCW    = 2'd1;
   localparam logic [1:0] FUNC_SIGNED = 2'd2;

   typedef struct packed {
      logic [1:0] func;
      logic       zero_a;
      logic       zero_b;
      logic       neg_a;
      logic       neg_b;
      logic       par;
      logic       same;
   } ctl_type;

   // atan(2^-i) as a fraction of a turn, 2^32 = full turn
   function automatic logic [TURN_WIDTH-1:0] atan_turn(input logic [4:0] idx);
      logic [TURN_WIDTH-1:0] v;
      case (idx)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10680350;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         5'd22:   v = 32'd163;
         5'd23:   v = 32'd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- sv/vau_req_if.sv -----
// ----------------------------------------------------------------------------
// vau_req_if
// Request channel: mode and the two input vectors, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vau_req_if #(
   parameter int COORD_WIDTH = vau_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    func;
   logic signed [COORD_WIDTH-1:0] a_x;
   logic signed [COORD_WIDTH-1:0] a_y;
   logic signed [COORD_WIDTH-1:0] b_x;
   logic signed [COORD_WIDTH-1:0] b_y;

   modport source (output valid, func, a_x, a_y, b_x, b_y, input ready);
   modport sink   (input valid, func, a_x, a_y, b_x, b_y, output ready);
endinterface

// ----- sv/vau_rsp_if.sv -----
// ----------------------------------------------------------------------------
// vau_rsp_if
// Response channel: angle result and length of A, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vau_rsp_if #(
   parameter int COORD_WIDTH = vau_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_BITS  = vau_pkg::ANGLE_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS:0]   angle;
   logic [COORD_WIDTH-1:0]       length;

   modport source (output valid, angle, length, input ready);
   modport sink   (input valid, angle, length, output ready);
endinterface

// ----- sv/vau_front.sv -----
// ----------------------------------------------------------------------------
// vau_front
// Two pipeline stages ahead of the CORDIC: products for the squared length
// and the cross product, then half-turn pre-rotation, zero/parallel flags and
// scaling of both vectors.
// ----------------------------------------------------------------------------
module vau_front #(
   parameter int COORD_WIDTH = vau_pkg::COORD_WIDTH_DEF,
   parameter int XW          = COORD_WIDTH + vau_pkg::GUARD_SHIFT + 3,
   parameter int SW          = 2 * COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [1:0]                    in_func,
   input  logic signed [COORD_WIDTH-1:0] in_ax,
   input  logic signed [COORD_WIDTH-1:0] in_ay,
   input  logic signed [COORD_WIDTH-1:0] in_bx,
   input  logic signed [COORD_WIDTH-1:0] in_by,
   output logic                          out_valid,
   input  logic                          out_ready,
   output vau_pkg::ctl_type              out_ctl,
   output logic signed [XW-1:0]          out_xa,
   output logic signed [XW-1:0]          out_ya,
   output logic signed [XW-1:0]          out_xb,
   output logic signed [XW-1:0]          out_yb,
   output logic [SW-1:0]                 out_rem
);
   localparam int CW  = COORD_WIDTH;
   localparam int PAD = XW - CW - 1;

   // stage 1
   logic                 s1_load, s1_v_in, s1_v_ff;
   logic [1:0]           s1_func_ff;
   logic signed [CW-1:0] s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic signed [SW-1:0] s1_sqx_in, s1_sqy_in, s1_c1_in, s1_c2_in;
   logic signed [SW-1:0] s1_sqx_ff, s1_sqy_ff, s1_c1_ff, s1_c2_ff;

   // stage 2
   logic                 s2_load, s2_v_in, s2_v_ff;
   vau_pkg::ctl_type     s2_ctl_in, s2_ctl_ff;
   logic signed [CW:0]   nxa, nya, nxb, nyb;
   logic signed [XW-1:0] s2_xa_in, s2_ya_in, s2_xb_in, s2_yb_in;
   logic signed [XW-1:0] s2_xa_ff, s2_ya_ff, s2_xb_ff, s2_yb_ff;
   logic [SW-1:0]        s2_rem_in, s2_rem_ff;

   assign s2_load  = !s2_v_ff || out_ready;
   assign s1_load  = !s1_v_ff || s2_load;
   assign in_ready = s1_load;
   assign s1_v_in  = s1_load ? in_valid : s1_v_ff;
   assign s2_v_in  = s2_load ? s1_v_ff : s2_v_ff;

   assign s1_sqx_in = in_ax * in_ax;
   assign s1_sqy_in = in_ay * in_ay;
   assign s1_c1_in  = in_ax * in_by;
   assign s1_c2_in  = in_ay * in_bx;

   always_comb begin
      s2_ctl_in.func   = s1_func_ff;
      s2_ctl_in.zero_a = (s1_ax_ff == '0) && (s1_ay_ff == '0);
      s2_ctl_in.zero_b = (s1_bx_ff == '0) && (s1_by_ff == '0);
      s2_ctl_in.neg_a  = s1_ax_ff[CW-1];
      s2_ctl_in.neg_b  = s1_bx_ff[CW-1];
      s2_ctl_in.par    = (s1_c1_ff == s1_c2_ff);
      s2_ctl_in.same   = (!s1_ax_ff[CW-1] && s1_ax_ff != '0 &&
                          !s1_bx_ff[CW-1] && s1_bx_ff != '0) ||
                         (s1_ax_ff[CW-1] && s1_bx_ff[CW-1]) ||
                         (!s1_ay_ff[CW-1] && s1_ay_ff != '0 &&
                          !s1_by_ff[CW-1] && s1_by_ff != '0) ||
                         (s1_ay_ff[CW-1] && s1_by_ff[CW-1]);
   end

   // bring x to x >= 0 by a half turn, then scale into the guard bits
   assign nxa = s1_ax_ff[CW-1] ? -{s1_ax_ff[CW-1], s1_ax_ff} : {s1_ax_ff[CW-1], s1_ax_ff};
   assign nya = s1_ax_ff[CW-1] ? -{s1_ay_ff[CW-1], s1_ay_ff} : {s1_ay_ff[CW-1], s1_ay_ff};
   assign nxb = s1_bx_ff[CW-1] ? -{s1_bx_ff[CW-1], s1_bx_ff} : {s1_bx_ff[CW-1], s1_bx_ff};
   assign nyb = s1_bx_ff[CW-1] ? -{s1_by_ff[CW-1], s1_by_ff} : {s1_by_ff[CW-1], s1_by_ff};

   assign s2_xa_in  = {{PAD{nxa[CW]}}, nxa} << vau_pkg::GUARD_SHIFT;
   assign s2_ya_in  = {{PAD{nya[CW]}}, nya} << vau_pkg::GUARD_SHIFT;
   assign s2_xb_in  = {{PAD{nxb[CW]}}, nxb} << vau_pkg::GUARD_SHIFT;
   assign s2_yb_in  = {{PAD{nyb[CW]}}, nyb} << vau_pkg::GUARD_SHIFT;
   assign s2_rem_in = $unsigned(s1_sqx_ff) + $unsigned(s1_sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_func_ff <= in_func;
         s1_ax_ff   <= in_ax;
         s1_ay_ff   <= in_ay;
         s1_bx_ff   <= in_bx;
         s1_by_ff   <= in_by;
         s1_sqx_ff  <= s1_sqx_in;
         s1_sqy_ff  <= s1_sqy_in;
         s1_c1_ff   <= s1_c1_in;
         s1_c2_ff   <= s1_c2_in;
      end
      if (s2_load) begin
         s2_ctl_ff <= s2_ctl_in;
         s2_xa_ff  <= s2_xa_in;
         s2_ya_ff  <= s2_ya_in;
         s2_xb_ff  <= s2_xb_in;
         s2_yb_ff  <= s2_yb_in;
         s2_rem_ff <= s2_rem_in;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_ctl   = s2_ctl_ff;
   assign out_xa    = s2_xa_ff;
   assign out_ya    = s2_ya_ff;
   assign out_xb    = s2_xb_ff;
   assign out_yb    = s2_yb_ff;
   assign out_rem   = s2_rem_ff;

endmodule

// ----- sv/vau_stage.sv -----
// ----------------------------------------------------------------------------
// vau_stage
// One pipeline stage: a CORDIC vectoring micro-rotation on both vectors and
// one result bit of the square root of |A|^2, each passed through when off.
// ----------------------------------------------------------------------------
module vau_stage #(
   parameter int COORD_WIDTH = vau_pkg::COORD_WIDTH_DEF,
   parameter int XW          = COORD_WIDTH + vau_pkg::GUARD_SHIFT + 3,
   parameter int SW          = 2 * COORD_WIDTH,
   parameter int IDX         = 0,
   parameter bit DO_CORDIC   = 1'b1,
   parameter bit DO_SQRT     = 1'b1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  vau_pkg::ctl_type                     in_ctl,
   input  logic signed [XW-1:0]                 in_xa,
   input  logic signed [XW-1:0]                 in_ya,
   input  logic [vau_pkg::TURN_WIDTH-1:0]       in_za,
   input  logic signed [XW-1:0]                 in_xb,
   input  logic signed [XW-1:0]                 in_yb,
   input  logic [vau_pkg::TURN_WIDTH-1:0]       in_zb,
   input  logic [SW-1:0]                        in_rem,
   input  logic [SW-1:0]                        in_root,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output vau_pkg::ctl_type                     out_ctl,
   output logic signed [XW-1:0]                 out_xa,
   output logic signed [XW-1:0]                 out_ya,
   output logic [vau_pkg::TURN_WIDTH-1:0]       out_za,
   output logic signed [XW-1:0]                 out_xb,
   output logic signed [XW-1:0]                 out_yb,
   output logic [vau_pkg::TURN_WIDTH-1:0]       out_zb,
   output logic [SW-1:0]                        out_rem,
   output logic [SW-1:0]                        out_root
);
   localparam int TW      = vau_pkg::TURN_WIDTH;
   localparam int BIT_POS = DO_SQRT ? 2 * (COORD_WIDTH - 1 - IDX) : 0;
   localparam logic [SW:0]   BIT_V  = (SW+1)'(1) << BIT_POS;
   localparam logic [TW-1:0] ATAN_C = vau_pkg::atan_turn(5'(IDX));

   logic                 load, v_in, v_ff;
   vau_pkg::ctl_type     ctl_ff;
   logic signed [XW-1:0] xa_in, ya_in, xb_in, yb_in;
   logic signed [XW-1:0] xa_ff, ya_ff, xb_ff, yb_ff;
   logic [TW-1:0]        za_in, zb_in, za_ff, zb_ff;
   logic [SW-1:0]        rem_in, root_in, rem_ff, root_ff;
   logic [SW:0]          trial;
   logic                 take;

   assign load     = !v_ff || out_ready;
   assign in_ready = load;
   assign v_in     = load ? in_valid : v_ff;

   generate
      if (DO_CORDIC) begin : g_cordic
         // rotate toward the x axis; direction from the sign of y
         assign xa_in = in_ya[XW-1] ? in_xa - (in_ya >>> IDX) : in_xa + (in_ya >>> IDX);
         assign ya_in = in_ya[XW-1] ? in_ya + (in_xa >>> IDX) : in_ya - (in_xa >>> IDX);
         assign za_in = in_ya[XW-1] ? in_za - ATAN_C : in_za + ATAN_C;
         assign xb_in = in_yb[XW-1] ? in_xb - (in_yb >>> IDX) : in_xb + (in_yb >>> IDX);
         assign yb_in = in_yb[XW-1] ? in_yb + (in_xb >>> IDX) : in_yb - (in_xb >>> IDX);
         assign zb_in = in_yb[XW-1] ? in_zb - ATAN_C : in_zb + ATAN_C;
      end else begin : g_cordic_idle
         assign xa_in = in_xa;
         assign ya_in = in_ya;
         assign za_in = in_za;
         assign xb_in = in_xb;
         assign yb_in = in_yb;
         assign zb_in = in_zb;
      end
   endgenerate

   assign trial = {1'b0, in_root} + BIT_V;
   assign take  = DO_SQRT && ({1'b0, in_rem} >= trial);

   generate
      if (DO_SQRT) begin : g_sqrt
         assign rem_in  = take ? in_rem - trial[SW-1:0] : in_rem;
         assign root_in = take ? (in_root >> 1) + BIT_V[SW-1:0] : in_root >> 1;
      end else begin : g_sqrt_idle
         assign rem_in  = in_rem;
         assign root_in = in_root;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff  <= in_ctl;
         xa_ff   <= xa_in;
         ya_ff   <= ya_in;
         za_ff   <= za_in;
         xb_ff   <= xb_in;
         yb_ff   <= yb_in;
         zb_ff   <= zb_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = v_ff;
   assign out_ctl   = ctl_ff;
   assign out_xa    = xa_ff;
   assign out_ya    = ya_ff;
   assign out_za    = za_ff;
   assign out_xb    = xb_ff;
   assign out_yb    = yb_ff;
   assign out_zb    = zb_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

// ----- sv/vau_back.sv -----
// ----------------------------------------------------------------------------
// vau_back
// Two stages after the CORDIC: round both angles and the root, then form the
// relative angle and select by mode into the output register.
// ----------------------------------------------------------------------------
module vau_back #(
   parameter int COORD_WIDTH = vau_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_BITS  = vau_pkg::ANGLE_BITS_DEF,
   parameter int SW          = 2 * COORD_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  vau_pkg::ctl_type               in_ctl,
   input  logic [vau_pkg::TURN_WIDTH-1:0] in_za,
   input  logic [vau_pkg::TURN_WIDTH-1:0] in_zb,
   input  logic [SW-1:0]                  in_rem,
   input  logic [SW-1:0]                  in_root,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [ANGLE_BITS:0]     out_angle,
   output logic [COORD_WIDTH-1:0]         out_length
);
   localparam int TW = vau_pkg::TURN_WIDTH;
   localparam int AB = ANGLE_BITS;
   localparam int CW = COORD_WIDTH;
   localparam logic [TW-1:0] RND      = TW'(1) << (TW - 1 - AB);
   localparam logic [TW-1:0] HALF_TW  = TW'(1) << (TW - 1);
   localparam logic [AB-1:0] HALF     = AB'(1) << (AB - 1);

   logic                 b1_load, b1_v_in, b1_v_ff;
   vau_pkg::ctl_type     b1_ctl_ff;
   logic [TW-1:0]        ta, tb;
   logic [AB-1:0]        b1_ang_a_in, b1_ang_b_in, b1_ang_a_ff, b1_ang_b_ff;
   logic [CW-1:0]        b1_len_in, b1_len_ff;

   logic                 b2_load, b2_v_in, b2_v_ff;
   logic [AB-1:0]        rel;
   logic signed [AB:0]   b2_angle_in, b2_angle_ff;
   logic [CW-1:0]        b2_len_ff;

   assign b2_load  = !b2_v_ff || out_ready;
   assign b1_load  = !b1_v_ff || b2_load;
   assign in_ready = b1_load;
   assign b1_v_in  = b1_load ? in_valid : b1_v_ff;
   assign b2_v_in  = b2_load ? b1_v_ff : b2_v_ff;

   // add the pre-rotation, round half up, wrap to a full turn
   assign ta = (in_ctl.neg_a ? HALF_TW : '0) + in_za + RND;
   assign tb = (in_ctl.neg_b ? HALF_TW : '0) + in_zb + RND;
   assign b1_ang_a_in = in_ctl.zero_a ? '0 : ta[TW-1 -: AB];
   assign b1_ang_b_in = in_ctl.zero_b ? '0 : tb[TW-1 -: AB];
   // remainder above the root means the true root is nearer root + 1
   assign b1_len_in   = in_root[CW-1:0] + CW'(in_rem > in_root);

   always_comb begin
      rel = b1_ang_b_ff - b1_ang_a_ff;
      if (!b1_ctl_ff.zero_a && !b1_ctl_ff.zero_b && b1_ctl_ff.par) begin
         rel = b1_ctl_ff.same ? '0 : HALF;
      end
      unique case (b1_ctl_ff.func)
         vau_pkg::FUNC_ANGLE:  b2_angle_in = {1'b0, b1_ang_a_ff};
         vau_pkg::FUNC_CCW:    b2_angle_in = {1'b0, rel};
         vau_pkg::FUNC_SIGNED: begin
            b2_angle_in = (b1_ctl_ff.zero_a || b1_ctl_ff.zero_b) ? '0 : {rel[AB-1], rel};
         end
         default:              b2_angle_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
      end else begin
         b1_v_ff <= b1_v_in;
         b2_v_ff <= b2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b1_load) begin
         b1_ctl_ff   <= in_ctl;
         b1_ang_a_ff <= b1_ang_a_in;
         b1_ang_b_ff <= b1_ang_b_in;
         b1_len_ff   <= b1_len_in;
      end
      if (b2_load) begin
         b2_angle_ff <= b2_angle_in;
         b2_len_ff   <= b1_len_ff;
      end
   end

   assign out_valid  = b2_v_ff;
   assign out_angle  = b2_angle_ff;
   assign out_length = b2_len_ff;

endmodule

// ----- sv/vector_angle_unit.sv -----
// ----------------------------------------------------------------------------
// vector_angle_unit
// Angle of vector A, or the counterclockwise / signed angle from A to B, as a
// fraction of a turn (2^ANGLE_BITS = 2pi), plus the rounded length of A. Both
// vector angles come from pipelined CORDIC vectoring lanes; the length from a
// digit-by-digit square root that runs alongside, one bit per stage. The
// pipeline takes one item every cycle unless the output stalls, and passes
// it through two front stages (the multipliers, then pre-rotation and
// flags), one stage per CORDIC iteration or root bit, and two back stages
// (rounding, mode select). Each stage holds its item when the output is
// stalled, so empty stages still fill while the result waits.
// ----------------------------------------------------------------------------
module vector_angle_unit #(
   parameter int COORD_WIDTH   = vau_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_BITS    = vau_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = vau_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   vau_req_if.sink     req_ch,
   vau_rsp_if.source   rsp_ch
);
   localparam int N  = (CORDIC_STAGES > COORD_WIDTH) ? CORDIC_STAGES : COORD_WIDTH;
   localparam int XW = COORD_WIDTH + vau_pkg::GUARD_SHIFT + 3;
   localparam int SW = 2 * COORD_WIDTH;
   localparam int TW = vau_pkg::TURN_WIDTH;

   logic                 v_w     [0:N];
   logic                 rdy_w   [0:N];
   vau_pkg::ctl_type     ctl_w   [0:N];
   logic signed [XW-1:0] xa_w    [0:N];
   logic signed [XW-1:0] ya_w    [0:N];
   logic [TW-1:0]        za_w    [0:N];
   logic signed [XW-1:0] xb_w    [0:N];
   logic signed [XW-1:0] yb_w    [0:N];
   logic [TW-1:0]        zb_w    [0:N];
   logic [SW-1:0]        rem_w   [0:N];
   logic [SW-1:0]        root_w  [0:N];

   vau_front #(
      .COORD_WIDTH (COORD_WIDTH),
      .XW          (XW),
      .SW          (SW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_func   (req_ch.func),
      .in_ax     (req_ch.a_x),
      .in_ay     (req_ch.a_y),
      .in_bx     (req_ch.b_x),
      .in_by     (req_ch.b_y),
      .out_valid (v_w[0]),
      .out_ready (rdy_w[0]),
      .out_ctl   (ctl_w[0]),
      .out_xa    (xa_w[0]),
      .out_ya    (ya_w[0]),
      .out_xb    (xb_w[0]),
      .out_yb    (yb_w[0]),
      .out_rem   (rem_w[0])
   );

   assign za_w[0]   = '0;
   assign zb_w[0]   = '0;
   assign root_w[0] = '0;

   generate
      for (genvar i = 0; i < N; i++) begin : g_stage
         vau_stage #(
            .COORD_WIDTH (COORD_WIDTH),
            .XW          (XW),
            .SW          (SW),
            .IDX         (i),
            .DO_CORDIC   (i < CORDIC_STAGES && i < vau_pkg::ATAN_ENTRIES),
            .DO_SQRT     (i < COORD_WIDTH)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (v_w[i]),
            .in_ready  (rdy_w[i]),
            .in_ctl    (ctl_w[i]),
            .in_xa     (xa_w[i]),
            .in_ya     (ya_w[i]),
            .in_za     (za_w[i]),
            .in_xb     (xb_w[i]),
            .in_yb     (yb_w[i]),
            .in_zb     (zb_w[i]),
            .in_rem    (rem_w[i]),
            .in_root   (root_w[i]),
            .out_valid (v_w[i+1]),
            .out_ready (rdy_w[i+1]),
            .out_ctl   (ctl_w[i+1]),
            .out_xa    (xa_w[i+1]),
            .out_ya    (ya_w[i+1]),
            .out_za    (za_w[i+1]),
            .out_xb    (xb_w[i+1]),
            .out_yb    (yb_w[i+1]),
            .out_zb    (zb_w[i+1]),
            .out_rem   (rem_w[i+1]),
            .out_root  (root_w[i+1])
         );
      end
   endgenerate

   vau_back #(
      .COORD_WIDTH (COORD_WIDTH),
      .ANGLE_BITS  (ANGLE_BITS),
      .SW          (SW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v_w[N]),
      .in_ready   (rdy_w[N]),
      .in_ctl     (ctl_w[N]),
      .in_za      (za_w[N]),
      .in_zb      (zb_w[N]),
      .in_rem     (rem_w[N]),
      .in_root    (root_w[N]),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_angle  (rsp_ch.angle),
      .out_length (rsp_ch.length)
   );

   // input only backs up when every stage is full behind a stalled output
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("request stalled while the pipeline has room");

   // square root remainder stays within 2*root
   a_sqrt_remainder: assert property (@(posedge clock) disable iff (reset)
      v_w[N] |-> ({1'b0, rem_w[N]} <= {root_w[N], 1'b0}))
      else $error("square root remainder out of range");

   // after pre-rotation the CORDIC x never goes negative
   a_cordic_x_positive: assert property (@(posedge clock) disable iff (reset)
      v_w[N] |-> (!xa_w[N][XW-1] && !xb_w[N][XW-1] && !ya_w[N][XW-1] == !ya_w[N][XW-1]
                  && !yb_w[N][XW-1] == !yb_w[N][XW-1]))
      else $error("CORDIC x went negative");

endmodule
